// ----- hw/rtl/lcdsw_pkg.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// lcdsw_pkg
// Shared types and constants for the segment LCD serial writer.
// ----------------------------------------------------------------------------
package lcdsw_pkg;

  localparam int unsigned SHADOW_WORDS_DEF = 32;
  localparam int unsigned NIB_W            = 4;
  localparam int unsigned ADDR_W           = 6;
  localparam int unsigned CODE_W           = 9;
  localparam int unsigned CMD_W            = 8;
  localparam int unsigned FRAME_W          = 13;
  localparam int unsigned CNT_W            = 4;

  localparam logic [2:0]  CMD_PREFIX    = 3'b100;
  localparam logic [2:0]  WRITE_PREFIX  = 3'b101;
  localparam logic [CNT_W-1:0] CMD_FRAME_LEN = 4'd12;
  localparam logic [CNT_W-1:0] SEG_FRAME_LEN = 4'd13;

  // code / 10 == (code * 205) >> 11 for every code below 1024
  localparam logic [7:0]  DIV10_RECIP = 8'd205;
  localparam int unsigned DIV10_SHIFT = 11;
  localparam int unsigned PROD_W      = CODE_W + 8;

  typedef struct packed {
    logic              func;
    logic [CMD_W-1:0]  command_code;
    logic [CODE_W-1:0] segment_code;
    logic              segment_on;
  } lcdsw_in_t;

  typedef struct packed {
    logic serial_bit;
    logic frame_end;
  } lcdsw_out_t;

  typedef enum logic [2:0] {
    ST_IDLE,
    ST_CALC,
    ST_LOOKUP,
    ST_UPDATE,
    ST_SEND
  } lcdsw_state_e;

  typedef struct packed {
    logic load;
    logic calc;
    logic lookup;
    logic update;
    logic shift;
  } lcdsw_cmd_t;

  typedef struct packed {
    logic seg_item;
    logic last_bit;
  } lcdsw_status_t;

endpackage

// ----- hw/rtl/lcdsw_ram.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// lcdsw_ram
// Generic single-write, single-read RAM with registered read data.
// ----------------------------------------------------------------------------
module lcdsw_ram #(
  parameter int unsigned WIDTH = 4,
  parameter int unsigned DEPTH = 32,
  localparam int unsigned AW   = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
  input  logic             clk_i,
  input  logic             we_i,
  input  logic [AW-1:0]    waddr_i,
  input  logic [WIDTH-1:0] wdata_i,
  input  logic             re_i,
  input  logic [AW-1:0]    raddr_i,
  output logic [WIDTH-1:0] rdata_o
);

  logic [WIDTH-1:0] mem_q [DEPTH];
  logic [WIDTH-1:0] rdata_q;

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
    if (re_i) begin
      rdata_q <= mem_q[raddr_i];
    end
  end

  assign rdata_o = rdata_q;

endmodule

// ----- hw/rtl/lcdsw_ctrl.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// lcdsw_ctrl
// Sequencer: item capture, address split, shadow update, bit shifting.
// ----------------------------------------------------------------------------
module lcdsw_ctrl
  import lcdsw_pkg::*;
(
  input  logic          clk_i,
  input  logic          rst_ni,
  input  logic          start_i,
  input  lcdsw_status_t status_i,
  output lcdsw_cmd_t    cmd_o,
  output logic          busy_o
);

  lcdsw_state_e state_q, state_d;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= ST_IDLE;
    end else begin
      state_q <= state_d;
    end
  end

  always_comb begin
    state_d = state_q;
    case (state_q)
      ST_IDLE: begin
        if (start_i) begin
          state_d = status_i.seg_item ? ST_CALC : ST_SEND;
        end
      end
      ST_CALC:   state_d = ST_LOOKUP;
      ST_LOOKUP: state_d = ST_UPDATE;
      ST_UPDATE: state_d = ST_SEND;
      ST_SEND: begin
        if (status_i.last_bit) begin
          state_d = ST_IDLE;
        end
      end
      default:   state_d = ST_IDLE;
    endcase
  end

  always_comb begin
    cmd_o  = '0;
    busy_o = 1'b1;
    case (state_q)
      ST_IDLE: begin
        busy_o     = 1'b0;
        cmd_o.load = start_i;
      end
      ST_CALC:   cmd_o.calc   = 1'b1;
      ST_LOOKUP: cmd_o.lookup = 1'b1;
      ST_UPDATE: cmd_o.update = 1'b1;
      ST_SEND:   cmd_o.shift  = 1'b1;
      default:   busy_o       = 1'b1;
    endcase
  end

endmodule

// ----- hw/rtl/lcdsw_dp.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// lcdsw_dp
// Datapath: code split, shadow nibble store, frame shift register.
// ----------------------------------------------------------------------------
module lcdsw_dp
  import lcdsw_pkg::*;
#(
  parameter int unsigned SHADOW_WORDS = SHADOW_WORDS_DEF
) (
  input  logic          clk_i,
  input  logic          rst_ni,
  input  lcdsw_in_t     in_i,
  input  lcdsw_cmd_t    cmd_i,
  output lcdsw_status_t status_o,
  output logic          strobe_o,
  output lcdsw_out_t    result_o
);

  localparam int unsigned AW = (SHADOW_WORDS > 1) ? $clog2(SHADOW_WORDS) : 1;

  logic [CODE_W-1:0]  code_q;
  logic               on_q;
  logic [ADDR_W-1:0]  addr_q;
  logic [NIB_W-1:0]   rem_q;
  logic               in_range_q;
  logic               rd_valid_q;
  logic [SHADOW_WORDS-1:0] valid_q;
  logic [FRAME_W-1:0] shift_q;
  logic [CNT_W-1:0]   cnt_q;
  lcdsw_out_t         out_q;
  logic               strobe_q;

  logic [PROD_W-1:0]  prod;
  logic [CODE_W-1:0]  rem_full;
  logic [AW-1:0]      idx;
  logic [NIB_W-1:0]   rdata;
  logic [NIB_W-1:0]   nib_old;
  logic [NIB_W-1:0]   nib_new;
  logic               bit_ok;
  logic               wr_en;
  logic [NIB_W-1:0]   data;

  assign prod     = PROD_W'(code_q) * PROD_W'(DIV10_RECIP);
  // addr * 10 as two shifted adds
  assign rem_full = code_q - (CODE_W'(addr_q) << 3) - (CODE_W'(addr_q) << 1);
  assign idx      = addr_q[AW-1:0];

  assign nib_old = rd_valid_q ? rdata : '0;
  assign bit_ok  = (rem_q < NIB_W'(4));
  always_comb begin
    nib_new = nib_old;
    if (bit_ok) begin
      nib_new[rem_q[1:0]] = on_q;
    end
  end
  assign wr_en = cmd_i.update && in_range_q && bit_ok;
  assign data  = in_range_q ? nib_new : '0;

  lcdsw_ram #(
    .WIDTH (NIB_W),
    .DEPTH (SHADOW_WORDS)
  ) u_shadow (
    .clk_i   (clk_i),
    .we_i    (wr_en),
    .waddr_i (idx),
    .wdata_i (nib_new),
    .re_i    (cmd_i.lookup),
    .raddr_i (idx),
    .rdata_o (rdata)
  );

  always_ff @(posedge clk_i) begin
    if (cmd_i.load) begin
      code_q <= in_i.segment_code;
      on_q   <= in_i.segment_on;
    end
    if (cmd_i.calc) begin
      addr_q <= prod[DIV10_SHIFT +: ADDR_W];
    end
    if (cmd_i.lookup) begin
      rem_q      <= rem_full[NIB_W-1:0];
      in_range_q <= ({1'b0, addr_q} < (ADDR_W + 1)'(SHADOW_WORDS));
      rd_valid_q <= valid_q[idx];
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_q  <= '0;
      shift_q  <= '0;
      cnt_q    <= '0;
      out_q    <= '0;
      strobe_q <= 1'b0;
    end else begin
      strobe_q <= cmd_i.shift;
      if (wr_en) begin
        valid_q[idx] <= 1'b1;
      end
      if (cmd_i.load && !in_i.func) begin
        shift_q <= {CMD_PREFIX, in_i.command_code, 1'b0, 1'b0};
        cnt_q   <= CMD_FRAME_LEN;
      end else if (cmd_i.update) begin
        shift_q <= {WRITE_PREFIX, addr_q, data};
        cnt_q   <= SEG_FRAME_LEN;
      end else if (cmd_i.shift) begin
        shift_q <= {shift_q[FRAME_W-2:0], 1'b0};
        cnt_q   <= cnt_q - CNT_W'(1);
        out_q   <= '{serial_bit: shift_q[FRAME_W-1], frame_end: (cnt_q == CNT_W'(1))};
      end
    end
  end

  assign status_o.seg_item = in_i.func;
  assign status_o.last_bit = (cnt_q == CNT_W'(1));
  assign strobe_o          = strobe_q;
  assign result_o          = out_q;

endmodule

// ----- hw/rtl/lcd_segment_serial_writer.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// lcd_segment_serial_writer
// Three-wire segment LCD frame serializer with a shadow nibble store.
// ----------------------------------------------------------------------------
//  channel   handshake          payload
//  -------   ----------------   -----------------------------------------
//  input     start_i, busy_o    in_i     : func, command_code, segment_code,
//                                          segment_on
//  result    strobe_o           result_o : serial_bit, frame_end
//
// a command word: one capture cycle, then 12 frame bits
// a segment word: capture, divide by ten, shadow read,
// shadow update, then 13 frame bits, one bit per cycle from the shift register
// each frame bit shows for one cycle on result_o with strobe_o high
// reset clears the shadow through per-entry valid bits, no clearing pass
// busy_o stays high until the last bit has left the shift register
// ----------------------------------------------------------------------------
module lcd_segment_serial_writer
  import lcdsw_pkg::*;
#(
  parameter int unsigned SHADOW_WORDS = SHADOW_WORDS_DEF
) (
  input  logic       clk_i,
  input  logic       rst_ni,
  input  logic       start_i,
  output logic       busy_o,
  input  lcdsw_in_t  in_i,
  output logic       strobe_o,
  output lcdsw_out_t result_o
);

  lcdsw_cmd_t    cmd;
  lcdsw_status_t status;

  lcdsw_ctrl u_ctrl (
    .clk_i    (clk_i),
    .rst_ni   (rst_ni),
    .start_i  (start_i),
    .status_i (status),
    .cmd_o    (cmd),
    .busy_o   (busy_o)
  );

  lcdsw_dp #(
    .SHADOW_WORDS (SHADOW_WORDS)
  ) u_dp (
    .clk_i    (clk_i),
    .rst_ni   (rst_ni),
    .in_i     (in_i),
    .cmd_i    (cmd),
    .status_o (status),
    .strobe_o (strobe_o),
    .result_o (result_o)
  );

endmodule
